### hdl/dspm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspm_pkg
// Types, codes and constants shared by the DMA sample playback mixer.
// ----------------------------------------------------------------------------
package dspm_pkg;

  localparam int STORE_BYTES_DEF = 65536;

  localparam logic [15:0] SRC_RATE      = 16'd50066;
  localparam logic [17:0] RATE_RESET    = 18'd44100;
  localparam logic [1:0]  MODE_RESET    = 2'd1;

  localparam logic [19:0] GAIN_M12DB    = 20'h01027;
  localparam logic [19:0] GAIN_MIXED    = 20'h10000;
  localparam logic [19:0] GAIN_SAMPLE   = 20'h40000;
  localparam logic [9:0]  TONE_WEIGHT   = 10'd768;

  localparam int DVD_W     = 25;
  localparam int DVS_W     = 18;
  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = 26;
  localparam int CFG_W     = 24;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_MIXER_MODE   = 3'd0,
    CFG_LOOP_ENABLE  = 3'd1,
    CFG_MONO_MODE    = 3'd2,
    CFG_RATE_SELECT  = 3'd3,
    CFG_BASE_ADDRESS = 3'd4,
    CFG_END_ADDRESS  = 3'd5,
    CFG_OUTPUT_RATE  = 3'd6
  } cfg_idx_t;

  localparam logic [1:0] MODE_M12DB  = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        store_address;
    logic [7:0]         store_byte;
    logic signed [15:0] tone_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               playing;
  } out_item_t;

  function automatic logic signed [19:0] gain_of(input logic [1:0] mode);
    logic signed [19:0] g;
    case (mode)
      MODE_M12DB:  g = GAIN_M12DB;
      MODE_SAMPLE: g = GAIN_SAMPLE;
      default:     g = GAIN_MIXED;
    endcase
    return g;
  endfunction

  function automatic logic [9:0] tone_weight_of(input logic [1:0] mode);
    return (mode == MODE_SAMPLE) ? 10'd0 : TONE_WEIGHT;
  endfunction

endpackage

### hdl/dspm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspm_store
// Sample byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dspm_store #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/dspm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspm_divider
// Restoring divider, one quotient bit per cycle, for the playback step.
// ----------------------------------------------------------------------------
module dspm_divider
  import dspm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] acc;
  logic [DVS_W:0]   rem_shift;
  logic             q_bit;
  logic [DVS_W-1:0] rem_next;

  always_comb begin
    rem_shift = {rem, acc[DVD_W-1]};
    q_bit     = (rem_shift >= {1'b0, dvs});
    rem_next  = q_bit ? DVS_W'(rem_shift - {1'b0, dvs}) : rem_shift[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS - 1);
        rem  <= '0;
        dvs  <= divisor;
        acc  <= dividend;
      end else if (busy) begin
        rem <= rem_next;
        acc <= {acc[DVD_W-2:0], q_bit};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = acc;

endmodule

### hdl/dma_sample_playback_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_sample_playback_mixer
// Plays signed 8-bit samples from a byte store at a fixed-point step and
// mixes them with a tone sample into 16-bit left and right results.
// ----------------------------------------------------------------------------
// Write and stop: the result follows the transfer directly through S_FINISH.
// Tick while playing: the result passes S_CHECK, S_ADDR_L, S_ADDR_R, S_LAT_R
//   and S_MULT, paced by the two sequential reads of the single store read port.
// Tick while stopped: S_CHECK and S_MULT only. Start: the result waits for the
//   bit-serial divider. A new transfer is taken only in S_IDLE, after the result.
// Reset clears control and configuration; store contents are undefined.
module dma_sample_playback_mixer
  import dspm_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  in_item_t         item,
  output logic             result_valid,
  input  logic             result_stall,
  output out_item_t        result
);

  localparam int ADDR_W = $clog2(STORE_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ADDR_L, S_ADDR_R, S_LAT_R, S_MULT,
    S_DIV_GO, S_DIV_WAIT, S_FINISH
  } state_t;

  state_t state;

  logic [1:0]        mixer_mode;
  logic              loop_enable;
  logic              mono_mode;
  logic [1:0]        rate_select;
  logic [23:0]       base_address;
  logic [23:0]       end_address;
  logic [DVS_W-1:0]  output_rate;

  logic              active;
  logic [31:0]       position;
  logic [31:0]       end_mark;
  logic [STEP_W-1:0] step_size;
  logic              mixed;
  logic signed [15:0] tone;
  logic signed [7:0] samp_l;
  logic signed [7:0] samp_r;
  logic signed [27:0] prod_l;
  logic signed [27:0] prod_r;
  logic signed [27:0] ym;

  logic              at_end;
  logic              rw_active;
  logic [31:0]       rw_position;
  logic [31:0]       rw_end_mark;
  logic [23:0]       byte_addr;
  logic [23:0]       addr_l;
  logic [23:0]       addr_r;
  logic [15:0]       frq;
  logic [DVD_W-1:0]  dividend;
  logic [DVD_W-1:0]  quotient;
  logic              div_done;
  logic              store_wr;
  logic [ADDR_W-1:0] store_rd_addr;
  logic [7:0]        store_rd_data;
  logic signed [27:0] sum_l;
  logic signed [27:0] sum_r;
  logic              accept;
  logic              out_free;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mixer_mode   <= MODE_RESET;
      loop_enable  <= 1'b0;
      mono_mode    <= 1'b0;
      rate_select  <= 2'd0;
      base_address <= '0;
      end_address  <= '0;
      output_rate  <= RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIXER_MODE:   mixer_mode   <= cfg_data[1:0];
        CFG_LOOP_ENABLE:  loop_enable  <= cfg_data[0];
        CFG_MONO_MODE:    mono_mode    <= cfg_data[0];
        CFG_RATE_SELECT:  rate_select  <= cfg_data[1:0];
        CFG_BASE_ADDRESS: base_address <= cfg_data;
        CFG_END_ADDRESS:  end_address  <= cfg_data;
        CFG_OUTPUT_RATE: begin
          if (cfg_data[DVS_W-1:0] != '0) begin
            output_rate <= cfg_data[DVS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Rewind or stop at the end of the region
  always_comb begin
    at_end      = (position >= end_mark);
    rw_end_mark = {end_address, 8'b0};
    if (loop_enable) begin
      rw_active   = active;
      rw_position = {base_address, 8'b0} - end_mark + position;
    end else begin
      rw_active   = 1'b0;
      rw_position = {base_address, 8'b0};
    end
  end

  always_comb begin
    byte_addr = position[31:8];
    addr_l    = mono_mode ? byte_addr : {byte_addr[23:1], 1'b0};
    addr_r    = mono_mode ? byte_addr : {byte_addr[23:1], 1'b1};
    store_rd_addr = (state == S_ADDR_R) ? addr_r[ADDR_W-1:0] : addr_l[ADDR_W-1:0];
    store_wr  = accept && (op_t'(item.operation) == OP_WRITE);
    frq       = SRC_RATE >> (rate_select ^ 2'd3);
    dividend  = mono_mode ? {1'b0, frq, 8'b0} : {frq, 9'b0};
    sum_l     = prod_l + ym;
    sum_r     = prod_r + ym;
  end

  dspm_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (ADDR_W'({8'b0, item.store_address})),
    .wr_data (item.store_byte),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  dspm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIV_GO),
    .dividend (dividend),
    .divisor  (output_rate),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      active       <= 1'b0;
      position     <= '0;
      end_mark     <= '0;
      step_size    <= '0;
      mixed        <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_FINISH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tone   <= item.tone_sample;
            prod_l <= '0;
            prod_r <= '0;
            ym     <= '0;
            unique case (op_t'(item.operation))
              OP_TICK:  state <= S_CHECK;
              OP_START: state <= S_DIV_GO;
              OP_STOP: begin
                active <= 1'b0;
                state  <= S_FINISH;
              end
              default:  state <= S_FINISH;
            endcase
          end
        end
        S_CHECK: begin
          mixed <= active && !(at_end && !loop_enable);
          if (active && at_end) begin
            active   <= rw_active;
            position <= rw_position;
            end_mark <= rw_end_mark;
          end
          state <= (active && !(at_end && !loop_enable)) ? S_ADDR_L : S_MULT;
        end
        S_ADDR_L: state <= S_ADDR_R;
        S_ADDR_R: begin
          samp_l <= store_rd_data;
          state  <= S_LAT_R;
        end
        S_LAT_R: begin
          samp_r   <= store_rd_data;
          position <= position + {6'b0, step_size};
          state    <= S_MULT;
        end
        S_MULT: begin
          ym <= 28'(tone) * 28'($signed({1'b0, tone_weight_of(mixer_mode)}));
          if (mixed) begin
            prod_l <= 28'(samp_l) * 28'(gain_of(mixer_mode));
            prod_r <= 28'(samp_r) * 28'(gain_of(mixer_mode));
            if (at_end) begin
              active   <= rw_active;
              position <= rw_position;
              end_mark <= rw_end_mark;
            end
          end
          state <= S_FINISH;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            active    <= 1'b1;
            position  <= {base_address, 8'b0};
            end_mark  <= {end_address, 8'b0};
            step_size <= STEP_W'(quotient);
            state     <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            result.left_out  <= sum_l[25:10];
            result.right_out <= sum_r[25:10];
            result.playing   <= active;
            result_valid     <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sim/dspm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspm_checker
// Watches the configuration port and both transfer channels of the DMA
// sample playback mixer. It keeps its own copy of the registers, the
// playback position and the sample store. For every accepted input transfer
// it predicts the mixed result. Each result transfer is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module dspm_checker
  import dspm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             item_valid,
  input  logic             item_stall,
  input  in_item_t         item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  out_item_t        result,
  output int               mismatches,
  output int               outstanding
);

  logic [1:0]  mode_q;
  logic        loop_q;
  logic        mono_q;
  logic [1:0]  rsel_q;
  logic [23:0] base_q;
  logic [23:0] last_q;
  logic [17:0] rate_q;

  logic        playing_q;
  logic [31:0] pos_q;
  logic [31:0] mark_q;
  logic [25:0] step_q;
  logic [7:0]  sample_mem [0:65535];

  out_item_t   expected_mix [$];
  int          seen;

  task automatic report_mismatch(input string what);
    $display("ERROR: %s", what);
    mismatches = mismatches + 1;
  endtask

  function automatic logic [15:0] shrink(input longint x);
    return 16'(x >>> 10);
  endfunction

  function automatic longint sample_at(input logic [31:0] a);
    return longint'($signed(sample_mem[a[15:0]]));
  endfunction

  task automatic rewind();
    if (!loop_q) begin
      playing_q = 1'b0;
      pos_q     = {base_q, 8'd0};
    end else begin
      pos_q = {base_q, 8'd0} - mark_q + pos_q;
    end
    mark_q = {last_q, 8'd0};
  endtask

  task automatic predict(input in_item_t it, output out_item_t r);
    longint      tone;
    longint      gain;
    longint      weighted;
    longint      lval;
    longint      rval;
    logic [31:0] addr;
    logic [31:0] frq;
    bit          mixed;
    r = '0;
    case (op_t'(it.operation))
      OP_WRITE: sample_mem[it.store_address] = it.store_byte;
      OP_START: begin
        frq       = 32'(SRC_RATE) >> (rsel_q ^ 2'd3);
        playing_q = 1'b1;
        pos_q     = {base_q, 8'd0};
        mark_q    = {last_q, 8'd0};
        step_q    = 26'((frq << (9 - mono_q)) / rate_q);
      end
      OP_STOP: playing_q = 1'b0;
      OP_TICK: begin
        tone = longint'($signed(it.tone_sample));
        case (mode_q)
          MODE_M12DB:  gain = longint'(GAIN_M12DB);
          MODE_SAMPLE: gain = longint'(GAIN_SAMPLE);
          default:     gain = longint'(GAIN_MIXED);
        endcase
        weighted = (mode_q == MODE_SAMPLE) ? 0 : tone * longint'(TONE_WEIGHT);
        mixed = playing_q;
        if (playing_q && pos_q >= mark_q) begin
          mixed = loop_q;
          rewind();
        end
        if (mixed) begin
          if (mono_q) begin
            lval = sample_at(pos_q >> 8);
            rval = lval;
          end else begin
            addr = (pos_q >> 8) & ~32'd1;
            lval = sample_at(addr);
            rval = sample_at(addr + 32'd1);
          end
          r.left_out  = shrink(lval * gain + weighted);
          r.right_out = shrink(rval * gain + weighted);
          pos_q = pos_q + 32'(step_q);
          if (pos_q >= mark_q) rewind();
        end else begin
          r.left_out  = shrink(weighted);
          r.right_out = shrink(weighted);
        end
      end
    endcase
    r.playing = playing_q;
  endtask

  always @(posedge clk) begin : track
    out_item_t want;
    if (rst) begin
      mode_q    = MODE_RESET;
      loop_q    = 1'b0;
      mono_q    = 1'b0;
      rsel_q    = 2'd0;
      base_q    = '0;
      last_q    = '0;
      rate_q    = RATE_RESET;
      playing_q = 1'b0;
      pos_q     = '0;
      mark_q    = '0;
      step_q    = '0;
      seen      = 0;
      expected_mix.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MIXER_MODE:   mode_q = cfg_data[1:0];
          CFG_LOOP_ENABLE:  loop_q = cfg_data[0];
          CFG_MONO_MODE:    mono_q = cfg_data[0];
          CFG_RATE_SELECT:  rsel_q = cfg_data[1:0];
          CFG_BASE_ADDRESS: base_q = cfg_data[23:0];
          CFG_END_ADDRESS:  last_q = cfg_data[23:0];
          CFG_OUTPUT_RATE:  if (cfg_data[17:0] != '0) rate_q = cfg_data[17:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_mix.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", seen));
        end else begin
          want = expected_mix.pop_front();
          if (result.left_out !== want.left_out)
            report_mismatch($sformatf("result %0d left_out got %0d expected %0d", seen,
                                      $signed(result.left_out), $signed(want.left_out)));
          if (result.right_out !== want.right_out)
            report_mismatch($sformatf("result %0d right_out got %0d expected %0d", seen,
                                      $signed(result.right_out), $signed(want.right_out)));
          if (result.playing !== want.playing)
            report_mismatch($sformatf("result %0d playing got %b expected %b", seen,
                                      result.playing, want.playing));
        end
        seen++;
      end
      if (item_valid && !item_stall) begin
        predict(item, want);
        expected_mix.push_back(want);
      end
    end
    outstanding <= expected_mix.size();
  end

endmodule

### sim/tb_dma_sample_playback_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dma_sample_playback_mixer
// Drives the DMA sample playback mixer with a short directed sequence and
// then with random playback phases: each phase loads the sample region it
// can reach, programs every register and plays start, tick, stop and write
// transfers under random gaps and result stalls. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_dma_sample_playback_mixer;
  import dspm_pkg::*;

  localparam int QUIET_CYCLES = 40;
  localparam int RANDOM_ITEMS = 750;
  localparam logic [1:0] MODE_MIXED     = 2'd1;
  localparam logic [1:0] MODE_MIXED_ALT = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             item_valid = 1'b0;
  logic             item_stall;
  in_item_t         item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  out_item_t        result;

  int mismatches;
  int outstanding;
  bit calm;
  int stall_run;
  bit stored [0:65535];
  int played;

  dma_sample_playback_mixer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  dspm_checker mix_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst || calm) begin
      result_stall <= 1'b0;
      stall_run    <= 0;
    end else if (stall_run > 0) begin
      result_stall <= 1'b1;
      stall_run    <= stall_run - 1;
    end else begin
      if ($urandom_range(0, 99) < 3) stall_run <= $urandom_range(8, 30);
      result_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [23:0] junk(input logic [23:0] v, input int w);
    if ($urandom_range(0, 3) != 0) return v;
    return v | (24'($urandom) << w);
  endfunction

  task automatic send_item(input op_t op, input logic [15:0] addr, input logic [7:0] data,
                           input logic [15:0] tone);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{operation: op, store_address: addr, store_byte: data, tone_sample: tone};
    if (op == OP_WRITE) stored[addr] = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    played++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input bit looping, input bit mono,
                           input logic [1:0] rsel, input logic [23:0] base,
                           input logic [23:0] last, input logic [17:0] rate,
                           input bit rate_zero);
    write_reg(CFG_MIXER_MODE, junk(24'(mode), 2));
    write_reg(CFG_LOOP_ENABLE, junk(24'(looping), 1));
    write_reg(CFG_MONO_MODE, junk(24'(mono), 1));
    write_reg(CFG_RATE_SELECT, junk(24'(rsel), 2));
    write_reg(CFG_BASE_ADDRESS, base);
    write_reg(CFG_END_ADDRESS, last);
    write_reg(CFG_OUTPUT_RATE, 24'(rate));
    if (rate_zero) write_reg(CFG_OUTPUT_RATE, {6'($urandom), 18'd0});
    cfg_write <= 1'b0;
  endtask

  task automatic load_bytes(input logic [23:0] lo, input logic [23:0] hi);
    int a;
    for (a = int'(lo); a <= int'(hi); a++)
      if (!stored[a[15:0]]) send_item(OP_WRITE, a[15:0], 8'($urandom), 16'($urandom));
  endtask

  task automatic play_phase();
    logic [23:0] base;
    logic [23:0] last;
    logic [17:0] rate;
    logic [1:0]  mode;
    logic [1:0]  rsel;
    bit          looping;
    bit          mono;
    int          pick;
    int          steps;
    calm <= ($urandom_range(0, 3) == 0);
    mode    = 2'($urandom_range(0, 3));
    rsel    = 2'($urandom_range(0, 3));
    looping = ($urandom_range(0, 9) < 4);
    mono    = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 4) base = 24'($urandom_range(0, 40));
    else if (pick < 7) base = 24'h00FFC0 + 24'($urandom_range(0, 40));
    else if (pick < 9) base = 24'hFFFF00 + 24'($urandom_range(0, 40));
    else base = 24'($urandom_range(0, 24'hFFFF00));
    // keep a looping region at least one step long so playback stays inside it
    last = base + 24'(looping ? $urandom_range(49, 96) : $urandom_range(1, 96));
    if (!looping && $urandom_range(0, 7) == 0)
      last = (base > 24'd4) ? base - 24'($urandom_range(0, 4)) : base;
    pick = $urandom_range(0, 9);
    // near the top of the address space a large step would wrap the position
    if (looping || base >= 24'hFE0000)
      rate = (pick == 0) ? 18'h3FFFF : 18'($urandom_range(2048, 200000));
    else if (pick < 2) rate = 18'd1;
    else if (pick < 4) rate = 18'($urandom_range(2, 300));
    else if (pick == 4) rate = 18'd200000;
    else if (pick == 5) rate = 18'h3FFFF;
    else rate = 18'($urandom_range(1, 200000));
    if (base < last) load_bytes(base & ~24'd1, last);
    drain();
    configure(mode, looping, mono, rsel, base, last, rate, $urandom_range(0, 5) == 0);
    send_item(OP_START, 16'($urandom), 8'($urandom), 16'($urandom));
    steps = $urandom_range(8, 48);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) send_item(OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
      else if (pick < 88) send_item(OP_WRITE, 16'($urandom), 8'($urandom), 16'($urandom));
      else if (pick < 94) send_item(OP_STOP, 16'($urandom), 8'($urandom), 16'($urandom));
      else send_item(OP_START, 16'($urandom), 8'($urandom), 16'($urandom));
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle after reset: tone only
    send_item(OP_TICK, 16'($urandom), 8'($urandom), 16'h7FFF);
    send_item(OP_TICK, 16'($urandom), 8'($urandom), 16'h8000);
    send_item(OP_TICK, 16'($urandom), 8'($urandom), 16'hFFFF);

    send_item(OP_WRITE, 16'h0000, 8'h80, 16'($urandom));
    send_item(OP_WRITE, 16'h0001, 8'h7F, 16'($urandom));
    send_item(OP_WRITE, 16'hFFFE, 8'hFF, 16'($urandom));
    send_item(OP_WRITE, 16'hFFFF, 8'h00, 16'($urandom));
    drain();

    // slowest output rate, then a zero rate write that must be dropped
    configure(MODE_M12DB, 1'b0, 1'b0, 2'd3, 24'h000000, 24'h000002, 18'd1, 1'b1);
    send_item(OP_START, 16'($urandom), 8'($urandom), 16'($urandom));
    send_item(OP_TICK, 16'($urandom), 8'($urandom), 16'h7FFF);
    send_item(OP_TICK, 16'($urandom), 8'($urandom), 16'h8000);
    send_item(OP_STOP, 16'($urandom), 8'($urandom), 16'($urandom));
    drain();

    // empty looping region at the top of the address space
    configure(MODE_MIXED_ALT, 1'b1, 1'b1, 2'd3, 24'hFFFFFF, 24'hFFFFFF, 18'h3FFFF, 1'b0);
    send_item(OP_START, 16'($urandom), 8'($urandom), 16'($urandom));
    repeat (3) send_item(OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
    drain();

    // start beyond the end: first tick stops playback
    configure(MODE_MIXED, 1'b0, 1'b0, 2'd0, 24'd4, 24'd2, 18'd44100, 1'b0);
    send_item(OP_START, 16'($urandom), 8'($urandom), 16'($urandom));
    send_item(OP_TICK, 16'($urandom), 8'($urandom), 16'h4000);
    send_item(OP_TICK, 16'($urandom), 8'($urandom), 16'hC000);
    drain();

    while (played < RANDOM_ITEMS) play_phase();
    drain();

    if (mismatches == 0 && outstanding == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
